FILE: rtl/core/shuffled_lcg_uniform_generator_assert.svh
`ifndef SHUFFLED_LCG_UNIFORM_GENERATOR_ASSERT_SVH
`define SHUFFLED_LCG_UNIFORM_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLCG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLCG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/slcg_pkg.sv
package slcg_pkg;

    localparam int TABLE_SIZE = 32;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 8);
    localparam int VAL_W      = 31;
    localparam int MUL_W      = 15;
    localparam int PROD_W     = VAL_W + MUL_W;
    localparam int FRAC_W     = 32;
    localparam int QDEPTH     = 2;

    localparam logic [VAL_W-1:0] MODULUS     = 31'h7FFF_FFFF;
    localparam logic [MUL_W-1:0] MULTIPLIER  = 15'd16807;
    localparam logic [VAL_W-1:0] CLAMP_LIMIT = 31'd2147483389;
    localparam logic [CNT_W-1:0] WARM_STEPS  = CNT_W'(TABLE_SIZE + 7);
    // Slot divisor is 1 + (2^31 - 2) / TABLE_SIZE, a power of two for a power-of-two table.
    localparam int SLOT_SHIFT = VAL_W - IDX_W;

    typedef struct packed {
        logic restart;
    } req_t;

    // Q0.32 of m / (2^31 - 1) with m < 2^31 - 1 equals 2m + (m >= 2^30).
    function automatic logic [FRAC_W-1:0] to_fraction(input logic [VAL_W-1:0] x);
        logic [VAL_W-1:0] m;
        begin
            m = (x > CLAMP_LIMIT) ? CLAMP_LIMIT : x;
            to_fraction = {m, m[VAL_W-1]};
        end
    endfunction

endpackage

FILE: rtl/core/slcg_front.sv
module slcg_front
    import slcg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    output logic       q_valid,
    input  logic       q_ready,
    output req_t       q_req
);

    localparam int PTR_W = $clog2(QDEPTH);

    logic             entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push, pop;

    assign s_tready = (count_reg != (PTR_W+1)'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_req.restart = entry_reg[rd_ptr_reg];

    assign push = s_tvalid && s_tready;
    assign pop  = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Only bit 0 carries the restart flag; the rest of the byte is padding.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_tdata[0];
        end
    end

endmodule

FILE: rtl/core/slcg_back.sv
module slcg_back
    import slcg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [VAL_W-1:0] seed,
    input  logic             q_valid,
    output logic             q_ready,
    input  req_t             q_req,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WARM_MUL,
        ST_WARM_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [VAL_W-1:0]    gen_reg;
    logic [VAL_W-1:0]    last_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [VAL_W-1:0]    rd_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                warm_reg;
    logic                out_valid_reg;
    logic [VAL_W-1:0]    out_draw_reg;
    logic [FRAC_W-1:0]   out_frac_reg;

    logic [VAL_W-1:0]    table_mem [TABLE_SIZE];
    logic                tbl_we;
    logic [IDX_W-1:0]    tbl_waddr;
    logic [IDX_W-1:0]    slot;
    logic [VAL_W:0]      fold;
    logic [VAL_W-1:0]    gen_new;
    logic [VAL_W-1:0]    seed_fix;
    logic                out_free;

    // Fold the product modulo 2^31 - 1: high part plus low part, then one correction.
    always_comb begin
        fold    = {1'b0, prod_reg[VAL_W-1:0]} + (VAL_W+1)'(prod_reg[PROD_W-1:VAL_W]);
        gen_new = (fold >= {1'b0, MODULUS}) ? VAL_W'(fold - {1'b0, MODULUS})
                                            : fold[VAL_W-1:0];
    end

    assign seed_fix = (seed == '0 || seed == MODULUS) ? VAL_W'(1) : seed;
    assign slot     = last_reg[VAL_W-1:SLOT_SHIFT];
    assign out_free = !out_valid_reg || m_tready;
    assign q_ready  = (state_reg == ST_IDLE);

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = slot;
        case (state_reg)
            ST_WARM_RED: begin
                tbl_we    = (cnt_reg < CNT_W'(TABLE_SIZE));
                tbl_waddr = cnt_reg[IDX_W-1:0];
            end
            ST_DRAW_RED: begin
                tbl_we    = 1'b1;
                tbl_waddr = slot;
            end
            default: begin
                tbl_we    = 1'b0;
                tbl_waddr = slot;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            table_mem[tbl_waddr] <= gen_new;
        end
        if (state_reg == ST_DRAW_MUL) begin
            rd_reg <= table_mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gen_reg       <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            warm_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            // Drop the taken result unless a new one loads in this cycle.
            if (out_valid_reg && m_tready && state_reg != ST_EMIT) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        if (q_req.restart || warm_reg) begin
                            gen_reg   <= seed_fix;
                            cnt_reg   <= WARM_STEPS;
                            state_reg <= ST_WARM_MUL;
                        end else begin
                            state_reg <= ST_DRAW_MUL;
                        end
                    end
                end
                ST_WARM_MUL: begin
                    state_reg <= ST_WARM_RED;
                end
                ST_WARM_RED: begin
                    gen_reg <= gen_new;
                    if (cnt_reg == '0) begin
                        // Last warm-up step fills slot 0, which seeds the first index.
                        last_reg  <= gen_new;
                        warm_reg  <= 1'b0;
                        state_reg <= ST_DRAW_MUL;
                    end else begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= ST_WARM_MUL;
                    end
                end
                ST_DRAW_MUL: begin
                    state_reg <= ST_DRAW_RED;
                end
                ST_DRAW_RED: begin
                    gen_reg   <= gen_new;
                    last_reg  <= rd_reg;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    // Hold the result until the output register frees up.
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_draw_reg  <= last_reg;
                        out_frac_reg  <= to_fraction(last_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WARM_MUL || state_reg == ST_DRAW_MUL) begin
            prod_reg <= PROD_W'(gen_reg) * PROD_W'(MULTIPLIER);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_frac_reg, out_draw_reg};

endmodule

FILE: rtl/core/shuffled_lcg_uniform_generator.sv
// Uniform random source: each request on the s_ channel returns one draw on the m_
// channel. The core is the minimal-standard multiplicative generator
// g' = 16807 * g mod (2^31 - 1), whose values pass through a 32-entry shuffle table.
// A request is popped from the request queue, runs one generator step (a registered
// 31x15 multiply, then the modulus fold) and loads the output register once it is
// free. A request with restart set, and the first request after reset, first load
// the generator from the seed (0 or 2^31 - 1 load as 1) and run 40 warm-up steps.
// Up to two requests queue ahead of the engine while a finished result waits in the
// output register. The user must write the seed through cfg_wr_en / cfg_wr_data
// only while no request is in flight; the block itself does not enforce this.
module shuffled_lcg_uniform_generator
    import slcg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,  // seed
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata       // [30:0] draw, [62:31] fraction, [63] zero
);

    logic [VAL_W-1:0] seed_reg;
    logic             q_valid;
    logic             q_ready;
    req_t             q_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= VAL_W'(1);
        end else if (cfg_wr_en) begin
            seed_reg <= cfg_wr_data;
        end
    end

    slcg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    slcg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .seed     (seed_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/core/slcg_checker.sv
`include "shuffled_lcg_uniform_generator_assert.svh"

module slcg_checker
    import slcg_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    logic [VAL_W-1:0]  draw;
    logic [FRAC_W-1:0] frac;

    assign draw = m_tdata[VAL_W-1:0];
    assign frac = m_tdata[VAL_W+FRAC_W-1:VAL_W];

    // A stalled result holds its payload.
    `SLCG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The generator never reaches zero or the modulus.
    `SLCG_ASSERT_NOW(a_draw_range, aclk, aresetn, m_tvalid, draw != '0 && draw != MODULUS, "draw out of range")

    // Below the clamp the fraction is twice the draw plus the top draw bit.
    `SLCG_ASSERT_NOW(a_frac_match, aclk, aresetn, m_tvalid && draw <= CLAMP_LIMIT, frac[FRAC_W-1:1] == draw && frac[0] == draw[VAL_W-1], "fraction does not match draw")

    // Above the clamp the fraction saturates.
    `SLCG_ASSERT_NOW(a_frac_clamp, aclk, aresetn, m_tvalid && draw > CLAMP_LIMIT, frac[FRAC_W-1:1] == CLAMP_LIMIT && !m_tdata[63], "fraction not clamped")

endmodule

bind shuffled_lcg_uniform_generator slcg_checker u_slcg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
